// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, case codes and sideband types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int FIELD_W    = 16;  // coefficient field width on the ports
  localparam int COEF_WIDTH = 16;  // coefficient width used by the math
  localparam int FRAC_BITS  = 16;  // fractional bits of the roots
  localparam int OUT_WIDTH  = 34;  // root field width
  localparam int CODE_W     = 3;

  localparam int D_W      = 2 * COEF_WIDTH + 2;         // signed discriminant
  localparam int DU_W     = 2 * COEF_WIDTH + 1;         // nonnegative discriminant
  localparam int SQ_STEPS = COEF_WIDTH + FRAC_BITS + 1; // root bits, one per stage
  localparam int RAD_W    = 2 * SQ_STEPS;               // radicand bits
  localparam int NUM_W    = SQ_STEPS + 1;               // dividend magnitude bits
  localparam int DEN_W    = COEF_WIDTH + 1;             // divisor magnitude bits
  localparam int SAT_W    = (NUM_W + 1 > OUT_WIDTH) ? NUM_W + 1 : OUT_WIDTH;

  typedef enum logic [CODE_W-1:0] {
    CASE_CONTRA = 3'd0,
    CASE_IDENT  = 3'd1,
    CASE_LINEAR = 3'd2,
    CASE_NONE   = 3'd3,
    CASE_DOUBLE = 3'd4,
    CASE_TWO    = 3'd5
  } case_t;

  typedef struct packed {
    case_t                         code;
    logic signed [COEF_WIDTH-1:0]  a;
    logic signed [COEF_WIDTH-1:0]  b;
    logic signed [COEF_WIDTH-1:0]  c;
  } sq_side_t;

  typedef struct packed {
    case_t code;
    logic  neg;
  } dv_side_t;

endpackage

// ===== hw/rtl/qrs_if.sv =====
// ----------------------------------------------------------------------------
// qrs_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface qrs_req_if;
  import qrs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] coef_quad;
  logic signed [FIELD_W-1:0] coef_lin;
  logic signed [FIELD_W-1:0] coef_const;
  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface qrs_rsp_if;
  import qrs_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [CODE_W-1:0]           case_code;
  logic signed [OUT_WIDTH-1:0] root_minus;
  logic signed [OUT_WIDTH-1:0] root_plus;
  modport source (output valid, case_code, root_minus, root_plus, input ready);
  modport sink   (input valid, case_code, root_minus, root_plus, output ready);
endinterface

// ===== hw/rtl/qrs_disc.sv =====
// ----------------------------------------------------------------------------
// qrs_disc
// Two stages: products b*b and a*c, then discriminant and case code.
// ----------------------------------------------------------------------------
module qrs_disc import qrs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COEF_WIDTH-1:0] a,
  input  logic signed [COEF_WIDTH-1:0] b,
  input  logic signed [COEF_WIDTH-1:0] c,
  output logic                         out_valid,
  output logic [DU_W-1:0]              d_mag,
  output sq_side_t                     side
);

  logic                           va;
  logic signed [COEF_WIDTH-1:0]   a_r, b_r, c_r;
  logic signed [2*COEF_WIDTH-1:0] bb, ac;
  logic signed [D_W-1:0]          d;
  case_t                          code;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a;
      b_r <= b;
      c_r <= c;
      bb  <= b * b;
      ac  <= a * c;
    end
  end

  assign d = D_W'(bb) - (D_W'(ac) <<< 2);

  always_comb begin
    if (a_r == '0) begin
      if (b_r == '0) begin
        code = (c_r == '0) ? CASE_IDENT : CASE_CONTRA;
      end else begin
        code = CASE_LINEAR;
      end
    end else if (d[D_W-1]) begin
      code = CASE_NONE;
    end else if (d == '0) begin
      code = CASE_DOUBLE;
    end else begin
      code = CASE_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_mag     <= d[DU_W-1:0];
      side.code <= code;
      side.a    <= a_r;
      side.b    <= b_r;
      side.c    <= c_r;
    end
  end

endmodule

// ===== hw/rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DU_W-1:0]     d,
  input  sq_side_t            in_side,
  output logic                out_valid,
  output logic [SQ_STEPS-1:0] root,
  output sq_side_t            out_side
);

  localparam int REM_W = SQ_STEPS + 2;

  logic                vld  [0:SQ_STEPS];
  logic [RAD_W-1:0]    rad  [0:SQ_STEPS];
  logic [REM_W-1:0]    rem  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] rt   [0:SQ_STEPS];
  sq_side_t            sd   [0:SQ_STEPS];

  assign vld[0] = in_valid;
  assign rad[0] = RAD_W'(d) << (2 * FRAC_BITS);
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic [REM_W-1:0] r2, trial;
    logic             ge;

    assign r2    = {rem[i][REM_W-3:0], rad[i][RAD_W-1 -: 2]};
    assign trial = {rt[i], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= rad[i] << 2;
        rem[i+1] <= ge ? (r2 - trial) : r2;
        rt[i+1]  <= {rt[i][SQ_STEPS-2:0], ge};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[SQ_STEPS];
  assign root      = rt[SQ_STEPS];
  assign out_side  = sd[SQ_STEPS];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  dv_side_t         in_side,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output dv_side_t         out_side
);

  logic             vld [0:NUM_W];
  logic [NUM_W-1:0] nq  [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [DEN_W-1:0] dv  [0:NUM_W];
  dv_side_t         sd  [0:NUM_W];

  assign vld[0] = in_valid;
  assign nq[0]  = num;
  assign rem[0] = '0;
  assign dv[0]  = den;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DEN_W:0] r2, diff;
    logic           ge;

    assign r2   = {rem[i], nq[i][NUM_W-1]};
    assign ge   = (r2 >= {1'b0, dv[i]});
    assign diff = r2 - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        nq[i+1]  <= {nq[i][NUM_W-2:0], ge};
        dv[i+1]  <= dv[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = nq[NUM_W];
  assign out_side  = sd[NUM_W];

endmodule

// ===== hw/rtl/quadratic_root_solver_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Solves a*x^2 + b*x + c = 0 for signed integer coefficients; returns a case
// code and two roots in signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless a result is held
// at the output. Coefficients are 16-bit and roots carry 16 fractional bits.
// Most of the stages belong to the square root, which makes one root bit per
// stage, and the divider, which makes one quotient bit per stage. The whole
// pipe advances together: when a result sits in the output register and the
// sink holds ready low, every stage and the request channel hold as well,
// so nothing is dropped or repeated. Roots are (-b*2^F -/+ s) / (2a),
// s = floor(sqrt(D) * 2^F), quotients truncate toward zero; a linear
// equation gives -c*2^F / b in both roots, and cases without roots give zero.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core import qrs_pkg::*; (
  input logic       clk,
  input logic       rst,
  qrs_req_if.sink   req,
  qrs_rsp_if.source rsp
);

  localparam int SN_W = NUM_W + 1;  // signed dividend width
  localparam int DS_W = DEN_W + 1;  // signed divisor width
  localparam logic signed [SAT_W-1:0] ROOT_MAX = (SAT_W'(1) <<< (OUT_WIDTH - 1)) - 1;
  localparam logic signed [SAT_W-1:0] ROOT_MIN = -ROOT_MAX - 1;

  // Global advance: the pipe moves whenever the output slot is free or drains.
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Field bits above COEF_WIDTH are ignored; narrower fields zero-extend.
  logic signed [COEF_WIDTH-1:0] a_in, b_in, c_in;
  assign a_in = COEF_WIDTH'($unsigned(req.coef_quad));
  assign b_in = COEF_WIDTH'($unsigned(req.coef_lin));
  assign c_in = COEF_WIDTH'($unsigned(req.coef_const));

  // Products and discriminant
  logic            dc_valid;
  logic [DU_W-1:0] dc_mag;
  sq_side_t        dc_side;

  qrs_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .a         (a_in),
    .b         (b_in),
    .c         (c_in),
    .out_valid (dc_valid),
    .d_mag     (dc_mag),
    .side      (dc_side)
  );

  // Square root of D * 2^(2F)
  logic                sq_valid;
  logic [SQ_STEPS-1:0] sq_root;
  sq_side_t            sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dc_valid),
    .d         (dc_mag),
    .in_side   (dc_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Dividend/divisor setup: signs split off, magnitudes go to the dividers.
  logic signed [SN_W-1:0] nb, s_x, nc, num0, num1;
  logic signed [DS_W-1:0] den2a, denb, den0;
  logic [NUM_W-1:0]       m0, m1;
  logic [DEN_W-1:0]       md0, md1;
  logic                   linear;

  assign linear = (sq_side.code == CASE_LINEAR);
  assign nb     = -(SN_W'(sq_side.b) <<< FRAC_BITS);
  assign nc     = -(SN_W'(sq_side.c) <<< FRAC_BITS);
  assign s_x    = SN_W'(sq_root);
  assign num0   = linear ? nc : (nb - s_x);
  assign num1   = nb + s_x;
  assign den2a  = DS_W'(sq_side.a) <<< 1;
  assign denb   = DS_W'(sq_side.b);
  assign den0   = linear ? denb : den2a;

  assign m0  = num0[SN_W-1] ? NUM_W'(-num0) : num0[NUM_W-1:0];
  assign m1  = num1[SN_W-1] ? NUM_W'(-num1) : num1[NUM_W-1:0];
  assign md0 = den0[DS_W-1] ? DEN_W'(-den0) : den0[DEN_W-1:0];
  assign md1 = den2a[DS_W-1] ? DEN_W'(-den2a) : den2a[DEN_W-1:0];

  logic             ns_valid;
  logic [NUM_W-1:0] ns_m0, ns_m1;
  logic [DEN_W-1:0] ns_d0, ns_d1;
  dv_side_t         ns_s0, ns_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_valid <= 1'b0;
    end else if (en) begin
      ns_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns_m0      <= m0;
      ns_m1      <= m1;
      ns_d0      <= md0;
      ns_d1      <= md1;
      ns_s0.code <= sq_side.code;
      ns_s0.neg  <= num0[SN_W-1] ^ den0[DS_W-1];
      ns_s1.code <= sq_side.code;
      ns_s1.neg  <= num1[SN_W-1] ^ den2a[DS_W-1];
    end
  end

  // Two divider lanes: minus root (or the linear root) and plus root.
  logic             dv0_valid, dv1_valid;
  logic [NUM_W-1:0] q0, q1;
  dv_side_t         dv0_side, dv1_side;

  qrs_div u_div_minus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ns_valid),
    .num       (ns_m0),
    .den       (ns_d0),
    .in_side   (ns_s0),
    .out_valid (dv0_valid),
    .quo       (q0),
    .out_side  (dv0_side)
  );

  qrs_div u_div_plus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ns_valid),
    .num       (ns_m1),
    .den       (ns_d1),
    .in_side   (ns_s1),
    .out_valid (dv1_valid),
    .quo       (q1),
    .out_side  (dv1_side)
  );

  // Sign restore, saturation and masking of rootless cases.
  logic signed [SAT_W-1:0]     v0, v1;
  logic signed [OUT_WIDTH-1:0] r0, r1;
  logic                        has_roots;

  assign v0 = dv0_side.neg ? -SAT_W'(q0) : SAT_W'(q0);
  assign v1 = dv1_side.neg ? -SAT_W'(q1) : SAT_W'(q1);
  assign r0 = (v0 > ROOT_MAX) ? OUT_WIDTH'(ROOT_MAX) :
              (v0 < ROOT_MIN) ? OUT_WIDTH'(ROOT_MIN) : OUT_WIDTH'(v0);
  assign r1 = (v1 > ROOT_MAX) ? OUT_WIDTH'(ROOT_MAX) :
              (v1 < ROOT_MIN) ? OUT_WIDTH'(ROOT_MIN) : OUT_WIDTH'(v1);
  assign has_roots = (dv0_side.code == CASE_LINEAR) || (dv0_side.code == CASE_DOUBLE) ||
                     (dv0_side.code == CASE_TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv0_valid;
    end
  end

  // Linear case: the plus lane divides by 2a = 0, so both outputs take lane 0.
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.case_code  <= dv0_side.code;
      rsp.root_minus <= has_roots ? r0 : '0;
      rsp.root_plus  <= !has_roots ? '0 :
                        (dv0_side.code == CASE_LINEAR) ? r0 : r1;
    end
  end

  // Both divider lanes move in lockstep.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    dv0_valid == dv1_valid)
    else $error("divider lanes out of step");

  // Cases without roots report zero roots.
  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.case_code == CASE_CONTRA || rsp.case_code == CASE_IDENT ||
                  rsp.case_code == CASE_NONE)
    |-> (rsp.root_minus == '0) && (rsp.root_plus == '0))
    else $error("nonzero root in a rootless case");

  // Linear and double-root cases give equal roots.
  a_equal_roots: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.case_code == CASE_LINEAR || rsp.case_code == CASE_DOUBLE)
    |-> rsp.root_minus == rsp.root_plus)
    else $error("roots differ in a single-root case");

  // A held result freezes the pipe and blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while result stalled");

endmodule

// ===== tb/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Watches the request and result channels of the quadratic root solver,
// predicts each result in order and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qrs_checker import qrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  qrs_req_if.sink req_mon,
  input  logic    req_ready,
  qrs_rsp_if.sink rsp_mon,
  input  logic    rsp_ready,
  output int      fail_count,
  output int      pending
);

  typedef struct {
    case_t            code;
    logic signed [OUT_WIDTH-1:0] rm;
    logic signed [OUT_WIDTH-1:0] rp;
  } solution_t;

  solution_t solutions_due[$];

  function automatic longint sext_coef(logic [FIELD_W-1:0] v);
    logic signed [COEF_WIDTH-1:0] t;
    t = v[COEF_WIDTH-1:0];
    return longint'(t);
  endfunction

  // digit-by-digit floor(sqrt(d * 2^(2F)))
  function automatic longint isqrt_fixed(longint d);
    logic [127:0] rad, rem, trial, root;
    rad = 128'(d) << (2 * FRAC_BITS);
    rem = 0;
    root = 0;
    for (int k = 31 + FRAC_BITS; k >= 0; k--) begin
      rem = (rem << 2) | ((rad >> (2 * k)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] clamp_root(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_WIDTH-1:0];
  endfunction

  function automatic solution_t solve_quadratic(logic [FIELD_W-1:0] qa,
                                                logic [FIELD_W-1:0] qb,
                                                logic [FIELD_W-1:0] qc);
    longint a, b, c, one, d, s, r1, r2;
    solution_t sol;
    a = sext_coef(qa);
    b = sext_coef(qb);
    c = sext_coef(qc);
    one = longint'(1) <<< FRAC_BITS;
    r1 = 0;
    r2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        sol.code = (c == 0) ? CASE_IDENT : CASE_CONTRA;
      end else begin
        sol.code = CASE_LINEAR;
        r1 = (-c * one) / b;
        r2 = r1;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0) begin
        sol.code = CASE_NONE;
      end else begin
        s = isqrt_fixed(d);
        r1 = (-b * one - s) / (2 * a);
        r2 = (-b * one + s) / (2 * a);
        sol.code = (d > 0) ? CASE_TWO : CASE_DOUBLE;
      end
    end
    sol.rm = clamp_root(r1);
    sol.rp = clamp_root(r2);
    return sol;
  endfunction

  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (req_mon.valid && req_ready)
        solutions_due.push_back(solve_quadratic(req_mon.coef_quad,
                                                req_mon.coef_lin,
                                                req_mon.coef_const));
      if (rsp_mon.valid && rsp_ready) begin
        if (solutions_due.size() == 0) begin
          $display("%0t: unexpected result code %0d", $time, rsp_mon.case_code);
          fail_count <= fail_count + 1;
        end else begin
          want = solutions_due.pop_front();
          if (rsp_mon.case_code !== want.code || rsp_mon.root_minus !== want.rm ||
              rsp_mon.root_plus !== want.rp) begin
            $display("%0t: mismatch exp code %0d minus %0d plus %0d, got %0d %0d %0d",
                     $time, want.code, want.rm, want.rp, rsp_mon.case_code,
                     rsp_mon.root_minus, rsp_mon.root_plus);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= solutions_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives coefficient requests into the quadratic root solver with bursty
// gaps and a stalling sink; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import qrs_pkg::*;

  localparam int LATENCY   = SQ_STEPS + NUM_W + 4;
  localparam int IDLE_MAX  = 20000;  // cycles with no handshake before giving up
  localparam int N_RANDOM  = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, idle_cycles;

  qrs_req_if req ();
  qrs_rsp_if rsp ();

  quadratic_root_solver_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  qrs_checker chk (
    .clk(clk), .rst(rst), .req_mon(req), .req_ready(req.ready),
    .rsp_mon(rsp), .rsp_ready(rsp.ready),
    .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  // sink stall pattern: runs of ready alternate with mostly stalled runs, sometimes none
  initial begin
    int run;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
      run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (run) begin
        rsp.ready <= ($urandom_range(0, 2) == 0);
        @(posedge clk);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  int burst_left = 0;

  // one request; valid stays high across back-to-back requests in a burst
  task automatic send_coefs(logic [15:0] qa, logic [15:0] qb, logic [15:0] qc);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    req.valid <= 1'b1;
    req.coef_quad <= qa;
    req.coef_lin <= qb;
    req.coef_const <= qc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_random();
    logic [15:0] qa, qb, qc;
    int kind;
    qa = 16'($urandom);
    qb = 16'($urandom);
    qc = 16'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: qa = '0;                                  // linear / degenerate
      1: begin qa = '0; qb = '0; if ($urandom_range(0, 1)) qc = '0; end
      2: begin                                     // small coefficients
        qa = 16'($signed($urandom_range(0, 20)) - 10);
        qb = 16'($signed($urandom_range(0, 20)) - 10);
        qc = 16'($signed($urandom_range(0, 20)) - 10);
      end
      3: begin                                     // double root: a*(x-r)^2
        qa = 16'($signed($urandom_range(1, 60)));
        qb = 16'(-2 * $signed(qa) * ($signed($urandom_range(0, 40)) - 20));
        qc = ($signed(qa) != 0) ? 16'(($signed(qb) * $signed(qb)) / (4 * $signed(qa)))
                                : 16'd0;
      end
      default: ;
    endcase
    send_coefs(qa, qb, qc);
  endtask

  initial begin
    req.valid = 1'b0;
    req.coef_quad = '0;
    req.coef_lin = '0;
    req.coef_const = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: each case and field extremes
    send_coefs(16'd0, 16'd0, 16'd5);         // contradiction
    send_coefs(16'd0, 16'd0, 16'd0);         // identity
    send_coefs(16'd0, 16'd3, 16'd7);         // linear
    send_coefs(16'd0, 16'h8000, 16'h7fff);   // linear, extremes
    send_coefs(16'd0, 16'hffff, 16'h8000);
    send_coefs(16'd1, 16'd0, 16'd1);         // no real roots
    send_coefs(16'd1, 16'd2, 16'd1);         // double root
    send_coefs(16'hffff, 16'd4, 16'hfffc);   // double root, negative a
    send_coefs(16'd1, 16'd0, 16'hffff);      // two roots
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h8000, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'hffff, 16'h7fff, 16'h7fff);
    send_coefs(16'd1, 16'h7fff, 16'd0);
    send_coefs(16'h5555, 16'haaaa, 16'h5555);
    send_coefs(16'haaaa, 16'h5555, 16'haaaa);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // hold off until the pipe has drained
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random();
    end
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
